@@ src/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by every module of the block.
package spq_pkg;

    localparam int CAPACITY_DEF = 8;
    localparam int VALUE_W      = 32;
    localparam int PRI_W        = 16;
    localparam int MODE_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int OCC_W        = 4;

    localparam logic [MODE_W-1:0] MODE_ENQ = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEQ = 2'd1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

    typedef enum logic
    {
        CTL_IDLE,
        CTL_BUSY
    } ctl_state_t;

    // controller to datapath
    typedef struct packed
    {
        logic load;   // capture request fields
        logic exec;   // apply held request, load result register
    } dp_cmd_t;

endpackage

@@ src/spq_datapath.sv @@
// Datapath: request holding registers, the row of sorted compare-and-shift
// slots, the entry count and the result register. Depends on spq_pkg.
module spq_datapath #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  spq_pkg::dp_cmd_t                    cmd,
    input  logic [spq_pkg::MODE_W-1:0]          mode,
    input  logic signed [spq_pkg::VALUE_W-1:0]  value,
    input  logic signed [spq_pkg::PRI_W-1:0]    priority_req,
    output logic [spq_pkg::STATUS_W-1:0]        status,
    output logic signed [spq_pkg::VALUE_W-1:0]  head_value,
    output logic signed [spq_pkg::PRI_W-1:0]    head_priority,
    output logic [spq_pkg::OCC_W-1:0]           occupancy,
    output logic                                is_empty,
    output logic                                is_full
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [MODE_W-1:0]         mode_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic signed [PRI_W-1:0]   pri_reg;

    logic signed [VALUE_W-1:0] val_reg  [CAPACITY];
    logic signed [PRI_W-1:0]   prio_reg [CAPACITY];
    logic signed [VALUE_W-1:0] val_next [CAPACITY];
    logic signed [PRI_W-1:0]   prio_next[CAPACITY];
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;

    logic [STATUS_W-1:0]       status_reg, status_next;
    logic signed [VALUE_W-1:0] head_value_reg, head_value_next;
    logic signed [PRI_W-1:0]   head_pri_reg, head_pri_next;
    logic [OCC_W-1:0]          occ_reg;
    logic                      empty_reg, full_reg;

    logic q_full, q_empty, do_enq, do_deq;
    logic [CAPACITY-1:0] keep;

    assign q_full  = (count_reg == CNT_W'(CAPACITY));
    assign q_empty = (count_reg == '0);
    assign do_enq  = (mode_reg == MODE_ENQ) && !q_full;
    assign do_deq  = (mode_reg == MODE_DEQ) && !q_empty;

    // Each slot decides on its own: keep, take the new entry, or shift.
    // Valid entries with priority <= new one form a prefix of the array.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
        logic signed [VALUE_W-1:0] ins_val, deq_val;
        logic signed [PRI_W-1:0]   ins_pri, deq_pri;

        assign keep[g] = (CNT_W'(g) < count_reg) && (prio_reg[g] <= pri_reg);

        if (g == 0) begin : g_head
            assign ins_val = keep[g] ? val_reg[g]  : value_reg;
            assign ins_pri = keep[g] ? prio_reg[g] : pri_reg;
        end
        else begin : g_body
            assign ins_val = keep[g]   ? val_reg[g]   :
                             keep[g-1] ? value_reg    : val_reg[g-1];
            assign ins_pri = keep[g]   ? prio_reg[g]  :
                             keep[g-1] ? pri_reg      : prio_reg[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign deq_val = val_reg[g];
            assign deq_pri = prio_reg[g];
        end
        else begin : g_mid
            assign deq_val = val_reg[g+1];
            assign deq_pri = prio_reg[g+1];
        end

        assign val_next[g]  = do_enq ? ins_val : (do_deq ? deq_val : val_reg[g]);
        assign prio_next[g] = do_enq ? ins_pri : (do_deq ? deq_pri : prio_reg[g]);
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_enq)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_deq)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        status_next = ST_OK;
        if (mode_reg == MODE_ENQ)
        begin
            if (q_full)
            begin
                status_next = ST_OVERFLOW;
            end
        end
        else if (q_empty)
        begin
            status_next = ST_EMPTY;
        end

        if (count_next != '0)
        begin
            head_value_next = val_next[0];
            head_pri_next   = prio_next[0];
        end
        else
        begin
            head_value_next = '0;
            head_pri_next   = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= mode;
            value_reg <= value;
            pri_reg   <= priority_req;
        end
        if (cmd.exec)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                val_reg[i]  <= val_next[i];
                prio_reg[i] <= prio_next[i];
            end
            status_reg     <= status_next;
            head_value_reg <= head_value_next;
            head_pri_reg   <= head_pri_next;
            occ_reg        <= OCC_W'(count_next);
            empty_reg      <= (count_next == '0);
            full_reg       <= (count_next == CNT_W'(CAPACITY));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    assign status        = status_reg;
    assign head_value    = head_value_reg;
    assign head_priority = head_pri_reg;
    assign occupancy     = occ_reg;
    assign is_empty      = empty_reg;
    assign is_full       = full_reg;

endmodule

@@ src/spq_ctrl.sv @@
// Controller: request handshake, execute sequencing and result valid.
// Depends on spq_pkg; drives the datapath through dp_cmd_t.
module spq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output spq_pkg::dp_cmd_t cmd
);
    import spq_pkg::*;

    ctl_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CTL_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b0;
        case (state_reg)
            CTL_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = CTL_BUSY;
                end
            end
            CTL_BUSY:
            begin
                in_stall = 1'b1;
                // result register must be free or emptying this cycle
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.exec   = 1'b1;
                    state_next = CTL_IDLE;
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
        out_valid_next = cmd.exec || (out_valid_reg && out_stall);
    end

    assign out_valid = out_valid_reg;

endmodule

@@ src/sorted_priority_queue.sv @@
// Channel  Handshake            Payload
// in       in_valid / in_stall  mode, value, priority_req
// out      out_valid/ out_stall status, head_value, head_priority, occupancy,
//                               is_empty, is_full
//
// A request is captured in IDLE; in BUSY all slots then compare and shift
// in parallel and load the result register. One request in flight.
// A waiting result does not block capture; execute waits for the result slot.
// Reset clears the entry count and handshake state; entry storage is not reset.
// Top level: sorted priority queue; depends on spq_pkg, spq_ctrl, spq_datapath.
module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [spq_pkg::MODE_W-1:0]          mode,
    input  logic signed [spq_pkg::VALUE_W-1:0]  value,
    input  logic signed [spq_pkg::PRI_W-1:0]    priority_req,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [spq_pkg::STATUS_W-1:0]        status,
    output logic signed [spq_pkg::VALUE_W-1:0]  head_value,
    output logic signed [spq_pkg::PRI_W-1:0]    head_priority,
    output logic [spq_pkg::OCC_W-1:0]           occupancy,
    output logic                                is_empty,
    output logic                                is_full
);
    import spq_pkg::*;

    dp_cmd_t cmd;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    spq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .mode          (mode),
        .value         (value),
        .priority_req  (priority_req),
        .status        (status),
        .head_value    (head_value),
        .head_priority (head_priority),
        .occupancy     (occupancy),
        .is_empty      (is_empty),
        .is_full       (is_full)
    );

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for sorted_priority_queue: random and directed requests
// against a cycle-free priority queue predictor, with random idle and stall on both sides.
// Depends on spq_pkg and the sorted_priority_queue RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int                  DEPTH      = CAPACITY_DEF;
    localparam logic [MODE_W-1:0]   MODE_PEEK  = 2'd2;
    localparam logic [MODE_W-1:0]   MODE_SPARE = 2'd3;   // undefined code, acts as peek
    localparam int                  IDLE_PCT   = 28;
    localparam int                  STUCK_MAX  = 3000;
    localparam int                  RAND_ITEMS = 1330;

    typedef struct {
        logic [MODE_W-1:0]          mode;
        logic signed [VALUE_W-1:0]  value;
        logic signed [PRI_W-1:0]    pri;
        bit                         drain_first;
    } request_t;

    typedef struct {
        logic [STATUS_W-1:0]        status;
        logic signed [VALUE_W-1:0]  head_value;
        logic signed [PRI_W-1:0]    head_priority;
        logic [OCC_W-1:0]           occupancy;
        logic                       is_empty;
        logic                       is_full;
    } head_report_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [MODE_W-1:0]          mode = MODE_PEEK;
    logic signed [VALUE_W-1:0]  value = '0;
    logic signed [PRI_W-1:0]    priority_req = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [STATUS_W-1:0]        status;
    logic signed [VALUE_W-1:0]  head_value;
    logic signed [PRI_W-1:0]    head_priority;
    logic [OCC_W-1:0]           occupancy;
    logic                       is_empty;
    logic                       is_full;

    request_t       req_backlog[$];
    head_report_t   report_due[$];

    // shadow of the queue contents, head at slot 0
    logic signed [VALUE_W-1:0]  shadow_val [DEPTH];
    logic signed [PRI_W-1:0]    shadow_pri [DEPTH];
    int                         shadow_cnt = 0;

    int unsigned    cyc = 0;
    int unsigned    stuck = 0;
    int unsigned    mismatch_cnt = 0;
    logic           quiet;

    sorted_priority_queue dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .value         (value),
        .priority_req  (priority_req),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .head_value    (head_value),
        .head_priority (head_priority),
        .occupancy     (occupancy),
        .is_empty      (is_empty),
        .is_full       (is_full)
    );

    always #10 clk = ~clk;

    // no idling on either side through this window
    assign quiet = (cyc >= 2000) && (cyc < 3500);

    task automatic apply_queue_op(input logic [MODE_W-1:0] op,
                                  input logic signed [VALUE_W-1:0] v,
                                  input logic signed [PRI_W-1:0] p);
        head_report_t r;
        int pos;
        r.status = ST_OK;
        if (op == MODE_ENQ) begin
            if (shadow_cnt >= DEPTH)
                r.status = ST_OVERFLOW;
            else begin
                // insert behind every entry of lower or equal priority
                pos = 0;
                for (int i = 0; i < shadow_cnt; i++)
                    if (shadow_pri[i] <= p)
                        pos = i + 1;
                for (int i = shadow_cnt; i > pos; i--) begin
                    shadow_val[i] = shadow_val[i-1];
                    shadow_pri[i] = shadow_pri[i-1];
                end
                shadow_val[pos] = v;
                shadow_pri[pos] = p;
                shadow_cnt++;
            end
        end else if (op == MODE_DEQ) begin
            if (shadow_cnt == 0)
                r.status = ST_EMPTY;
            else begin
                for (int i = 0; i + 1 < shadow_cnt; i++) begin
                    shadow_val[i] = shadow_val[i+1];
                    shadow_pri[i] = shadow_pri[i+1];
                end
                shadow_cnt--;
            end
        end else if (shadow_cnt == 0)
            r.status = ST_EMPTY;
        r.head_value    = (shadow_cnt > 0) ? shadow_val[0] : '0;
        r.head_priority = (shadow_cnt > 0) ? shadow_pri[0] : '0;
        r.occupancy     = shadow_cnt[OCC_W-1:0];
        r.is_empty      = (shadow_cnt == 0);
        r.is_full       = (shadow_cnt >= DEPTH);
        report_due.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    task automatic add_request(input logic [MODE_W-1:0] op, input logic [31:0] v,
                               input logic [15:0] p, input bit drain_first);
        request_t q;
        q.mode        = op;
        q.value       = v;
        q.pri         = p;
        q.drain_first = drain_first;
        req_backlog.push_back(q);
    endtask

    always @(posedge clk) begin
        cyc <= cyc + 1;
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck <= 0;
            else
                stuck <= stuck + 1;
            if (stuck >= STUCK_MAX) begin
                $display("%0t: no progress for %0d cycles", $time, stuck);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // request driver
    always @(posedge clk) begin
        bit offer;
        if (!rst_n)
            in_valid <= 1'b0;
        else begin
            if (in_valid && !in_stall) begin
                apply_queue_op(mode, value, priority_req);
                void'(req_backlog.pop_front());
            end
            if (!(in_valid && in_stall)) begin
                offer = (req_backlog.size() != 0)
                        && (quiet || ($urandom_range(99) >= IDLE_PCT));
                if (offer && req_backlog[0].drain_first && report_due.size() != 0)
                    offer = 1'b0;
                if (offer) begin
                    in_valid     <= 1'b1;
                    mode         <= req_backlog[0].mode;
                    value        <= req_backlog[0].value;
                    priority_req <= req_backlog[0].pri;
                end else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk) begin
        head_report_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else begin
            if (out_valid && !out_stall) begin
                if (report_due.size() == 0) begin
                    $display("%0t: result with nothing outstanding, got status %0d head %0d",
                             $time, status, head_value);
                    mismatch_cnt++;
                end else begin
                    want = report_due.pop_front();
                    check_field("status", want.status, status);
                    check_field("head_value", want.head_value, head_value);
                    check_field("head_priority", want.head_priority, head_priority);
                    check_field("occupancy", want.occupancy, occupancy);
                    check_field("is_empty", want.is_empty, is_empty);
                    check_field("is_full", want.is_full, is_full);
                end
            end
            out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
        end
    end

    initial begin
        int bias;
        int r;
        logic [MODE_W-1:0] op;
        logic [15:0] p;

        // empty queue corners
        add_request(MODE_PEEK, 32'h1234_5678, 16'h0001, 1'b0);
        add_request(MODE_DEQ, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        add_request(MODE_SPARE, 32'h0, 16'h0, 1'b0);
        // fill with extremes and ties
        add_request(MODE_ENQ, 32'h8000_0000, 16'h7FFF, 1'b0);
        add_request(MODE_ENQ, 32'h7FFF_FFFF, 16'h8000, 1'b0);
        add_request(MODE_ENQ, 32'd1, 16'd0, 1'b0);
        add_request(MODE_ENQ, 32'd2, 16'd0, 1'b0);
        add_request(MODE_ENQ, 32'd3, 16'd0, 1'b0);
        add_request(MODE_ENQ, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        add_request(MODE_ENQ, 32'd0, 16'h7FFF, 1'b0);
        add_request(MODE_ENQ, 32'd5, 16'd0, 1'b0);
        // full queue: overflow, then peeks
        add_request(MODE_ENQ, 32'h0000_FFFF, 16'h8000, 1'b0);
        add_request(MODE_PEEK, 32'h0, 16'h0, 1'b0);
        add_request(MODE_SPARE, 32'hA5A5_A5A5, 16'h5A5A, 1'b0);
        for (int i = 0; i < DEPTH; i++)
            add_request(MODE_DEQ, $urandom, 16'($urandom), 1'b0);
        add_request(MODE_DEQ, 32'h0, 16'h0, 1'b0);
        add_request(MODE_PEEK, 32'h0, 16'h0, 1'b0);

        // random part: runs of fill-heavy, drain-heavy and balanced traffic
        bias = 50;
        for (int k = 0; k < RAND_ITEMS; k++) begin
            if (k % 40 == 0)
                case ($urandom_range(2))
                    0: bias = 75;
                    1: bias = 25;
                    default: bias = 50;
                endcase
            r = $urandom_range(99);
            if (r < 4)
                op = MODE_SPARE;
            else if (r < 14)
                op = MODE_PEEK;
            else if ($urandom_range(99) < bias)
                op = MODE_ENQ;
            else
                op = MODE_DEQ;
            r = $urandom_range(99);
            if (r < 50)
                p = 16'($signed($urandom_range(6)) - 3);
            else if (r < 60)
                p = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            else
                p = 16'($urandom);
            add_request(op, $urandom, p, (k % 300) == 0);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (req_backlog.size() != 0 || report_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
